### src/vlsf_pkg.sv
package vlsf_pkg;

  localparam int unsigned CubeSideDef = 3;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned RgbW        = 3 * ChanW;
  localparam int unsigned FuncW       = 2;
  localparam int unsigned LedIdxW     = 5;
  localparam int unsigned NumLanes    = 8;
  localparam int unsigned LaneW       = 3;
  localparam logic [LaneW-1:0] LastLane = 3'b111;
  localparam logic [ChanW-1:0] ChanMax  = 8'hFF;
  localparam int unsigned CalcCycles  = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD_POINT = 2'd0,
    FUNC_ADD_INDEX = 2'd1,
    FUNC_READ      = 2'd2,
    FUNC_CLEAR     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MERGE,
    ST_INDEX,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic wr;
    logic clr;
  } store_ctl_t;

endpackage

### src/vlsf_lane.sv
module vlsf_lane import vlsf_pkg::*; #(
  parameter int unsigned CUBE_SIDE = CubeSideDef,
  parameter int unsigned FRAC_BITS = FracBitsDef,
  parameter int unsigned LANE_ID   = 0
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     lane_en_i,
  input  logic [CoordW-FRAC_BITS:0]                base_x_i,
  input  logic [CoordW-FRAC_BITS:0]                base_y_i,
  input  logic [CoordW-FRAC_BITS:0]                base_z_i,
  input  logic [FRAC_BITS-1:0]                     frac_x_i,
  input  logic [FRAC_BITS-1:0]                     frac_y_i,
  input  logic [FRAC_BITS-1:0]                     frac_z_i,
  input  logic [RgbW-1:0]                          rgb_i,
  output logic                                     hit_o,
  output logic [$clog2(CUBE_SIDE**3)-1:0]          idx_o,
  output logic [RgbW-1:0]                          part_o
);

  localparam int unsigned AxW  = CoordW - FRAC_BITS + 1;
  localparam int unsigned PosW = AxW + 1;
  localparam int unsigned WtW  = FRAC_BITS + 1;
  localparam int unsigned IdxW = $clog2(CUBE_SIDE**3);
  localparam logic [WtW-1:0] One = WtW'(1) << FRAC_BITS;
  localparam logic OffX = LANE_ID[0];
  localparam logic OffY = LANE_ID[1];
  localparam logic OffZ = LANE_ID[2];

  logic [PosW-1:0]   px, py, pz;
  logic              ok_x, ok_y, ok_z;
  logic [WtW-1:0]    wx, wy, wz;
  logic [2*WtW-1:0]  prod_xy;
  logic [2*WtW-1:0]  prod_w;
  logic [IdxW-1:0]   idx_d;
  logic [ChanW+WtW-1:0] prod_c [3];

  logic              hit1_q, hit2_q, hit3_q;
  logic [IdxW-1:0]   idx1_q, idx2_q, idx3_q;
  logic [WtW-1:0]    wxy_q, wz_q, w_q;
  logic [RgbW-1:0]   part_d, part_q;

  function automatic logic [WtW-1:0] axis_wt(input logic off, input logic [FRAC_BITS-1:0] f);
    logic [WtW-1:0] fe;
    fe = {1'b0, f};
    return off ? fe : One - fe;
  endfunction

  always_comb begin
    px = {1'b0, base_x_i} + PosW'(OffX);
    py = {1'b0, base_y_i} + PosW'(OffY);
    pz = {1'b0, base_z_i} + PosW'(OffZ);
    ok_x = (px >= PosW'(1)) && (px <= PosW'(CUBE_SIDE));
    ok_y = (py >= PosW'(1)) && (py <= PosW'(CUBE_SIDE));
    ok_z = (pz >= PosW'(1)) && (pz <= PosW'(CUBE_SIDE));
    wx = axis_wt(OffX, frac_x_i);
    wy = axis_wt(OffY, frac_y_i);
    wz = axis_wt(OffZ, frac_z_i);
    prod_xy = wx * wy;
    // only meaningful when all axes are in range
    idx_d = IdxW'(px - PosW'(1))
          + IdxW'(CUBE_SIDE) * IdxW'(py - PosW'(1))
          + IdxW'(CUBE_SIDE * CUBE_SIDE) * IdxW'(pz - PosW'(1));
    prod_w = wxy_q * wz_q;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_c[c] = rgb_i[c*ChanW +: ChanW] * w_q;
      part_d[c*ChanW +: ChanW] = prod_c[c][FRAC_BITS +: ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit1_q <= 1'b0;
      hit2_q <= 1'b0;
      hit3_q <= 1'b0;
    end else begin
      hit1_q <= lane_en_i && ok_x && ok_y && ok_z;
      hit2_q <= hit1_q;
      hit3_q <= hit2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_d;
    wxy_q  <= WtW'(prod_xy >> FRAC_BITS);
    wz_q   <= wz;
    idx2_q <= idx1_q;
    w_q    <= WtW'(prod_w >> FRAC_BITS);
    idx3_q <= idx2_q;
    part_q <= part_d;
  end

  assign hit_o  = hit3_q;
  assign idx_o  = idx3_q;
  assign part_o = part_q;

endmodule

### src/vlsf_store.sv
module vlsf_store import vlsf_pkg::*; #(
  parameter int unsigned CUBE_SIDE = CubeSideDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  store_ctl_t                        ctl_i,
  input  logic [$clog2(CUBE_SIDE**3)-1:0]   addr_i,
  input  logic [RgbW-1:0]                   add_i,
  output logic [RgbW-1:0]                   rd_data_o
);

  localparam int unsigned LedCount = CUBE_SIDE**3;

  logic [RgbW-1:0] frame_q [LedCount];
  logic [RgbW-1:0] sum_d;

  function automatic logic [ChanW-1:0] sat_add(input logic [ChanW-1:0] a,
                                               input logic [ChanW-1:0] b);
    logic [ChanW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ChanW] ? ChanMax : s[ChanW-1:0];
  endfunction

  assign rd_data_o = frame_q[addr_i];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c*ChanW +: ChanW] = sat_add(rd_data_o[c*ChanW +: ChanW], add_i[c*ChanW +: ChanW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LedCount; i++) begin
        frame_q[i] <= '0;
      end
    end else if (ctl_i.clr) begin
      for (int i = 0; i < LedCount; i++) begin
        frame_q[i] <= '0;
      end
    end else if (ctl_i.wr) begin
      frame_q[addr_i] <= sum_d;
    end
  end

endmodule

### src/voxel_light_splat_frame.sv
// point add: accept, then 3 weight stages in the lanes, then a read-modify-write of each
// of the 8 neighbors, one neighbor per cycle on the single frame port; index add and clear
// act on the store in a single state before the result, a read goes straight to the result
// sequencing: one transaction at a time, next input taken the cycle after the result is loaded
// reset: frame store cleared to zero, smooth_mode 0, no result pending
module voxel_light_splat_frame import vlsf_pkg::*; #(
  parameter int unsigned CUBE_SIDE = CubeSideDef,
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     smooth_mode_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FuncW-1:0]         func_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  input  logic [LedIdxW-1:0]       led_index_i,
  input  logic [ChanW-1:0]         red_i,
  input  logic [ChanW-1:0]         green_i,
  input  logic [ChanW-1:0]         blue_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ChanW-1:0]         out_red_o,
  output logic [ChanW-1:0]         out_green_o,
  output logic [ChanW-1:0]         out_blue_o
);

  localparam int unsigned LedCount = CUBE_SIDE**3;
  localparam int unsigned IdxW     = $clog2(LedCount);
  localparam int unsigned AxW      = CoordW - FRAC_BITS + 1;
  localparam logic [CoordW:0] Half = (CoordW+1)'(1) << (FRAC_BITS - 1);

  state_e state_q, state_d;
  logic [LaneW-1:0] cnt_q, cnt_d;
  logic smooth_q;

  logic [FuncW-1:0]   func_q;
  logic [LedIdxW-1:0] led_idx_q;
  logic [RgbW-1:0]    rgb_q;
  logic [AxW-1:0]     base_q [3];
  logic [FRAC_BITS-1:0] frac_q [3];
  logic [NumLanes-1:0]  lane_en_q;

  logic [AxW-1:0]       base_d [3];
  logic [FRAC_BITS-1:0] frac_d [3];
  logic [NumLanes-1:0]  lane_en_d;
  logic [CoordW-1:0]    co [3];
  logic                 neg;

  logic                 lane_hit  [NumLanes];
  logic [IdxW-1:0]      lane_idx  [NumLanes];
  logic [RgbW-1:0]      lane_part [NumLanes];

  store_ctl_t           st_ctl;
  logic [IdxW-1:0]      st_addr;
  logic [RgbW-1:0]      st_add;
  logic [RgbW-1:0]      st_rd;

  logic                 in_acc;
  logic                 load_out;
  logic                 idx_ok;
  logic                 out_valid_q;
  logic [RgbW-1:0]      out_rgb_q;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign idx_ok      = 32'(led_idx_q) < LedCount;

  // item setup: per-axis base position and fraction, lane mask
  always_comb begin
    co[0] = coord_x_i;
    co[1] = coord_y_i;
    co[2] = coord_z_i;
    neg = co[0][CoordW-1] || co[1][CoordW-1] || co[2][CoordW-1];
    for (int d = 0; d < 3; d++) begin
      if (smooth_q) begin
        base_d[d] = AxW'(co[d][CoordW-1:FRAC_BITS]);
        frac_d[d] = co[d][FRAC_BITS-1:0];
      end else begin
        // round half away from zero, axis known non-negative
        base_d[d] = AxW'(({1'b0, co[d]} + Half) >> FRAC_BITS);
        frac_d[d] = '0;
      end
    end
    if (neg || (func_i != FUNC_ADD_POINT)) begin
      lane_en_d = '0;
    end else if (smooth_q) begin
      lane_en_d = '1;
    end else begin
      lane_en_d = NumLanes'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      smooth_q <= smooth_mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q    <= func_i;
      led_idx_q <= led_index_i;
      rgb_q     <= {blue_i, green_i, red_i};
      lane_en_q <= lane_en_d;
      for (int d = 0; d < 3; d++) begin
        base_q[d] <= base_d[d];
        frac_q[d] <= frac_d[d];
      end
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    vlsf_lane #(
      .CUBE_SIDE (CUBE_SIDE),
      .FRAC_BITS (FRAC_BITS),
      .LANE_ID   (g)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .lane_en_i (lane_en_q[g]),
      .base_x_i  (base_q[0]),
      .base_y_i  (base_q[1]),
      .base_z_i  (base_q[2]),
      .frac_x_i  (frac_q[0]),
      .frac_y_i  (frac_q[1]),
      .frac_z_i  (frac_q[2]),
      .rgb_i     (rgb_q),
      .hit_o     (lane_hit[g]),
      .idx_o     (lane_idx[g]),
      .part_o    (lane_part[g])
    );
  end

  vlsf_store #(
    .CUBE_SIDE (CUBE_SIDE)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (st_ctl),
    .addr_i    (st_addr),
    .add_i     (st_add),
    .rd_data_o (st_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          case (func_e'(func_i))
            FUNC_ADD_POINT: state_d = ST_CALC;
            FUNC_ADD_INDEX: state_d = ST_INDEX;
            FUNC_READ:      state_d = ST_DONE;
            FUNC_CLEAR:     state_d = ST_CLEAR;
            default:        state_d = ST_DONE;
          endcase
        end
      end
      ST_CALC: begin
        if (cnt_q == LaneW'(CalcCycles - 1)) begin
          cnt_d   = '0;
          state_d = ST_MERGE;
        end else begin
          cnt_d = cnt_q + LaneW'(1);
        end
      end
      ST_MERGE: begin
        cnt_d = cnt_q + LaneW'(1);
        if (cnt_q == LastLane) begin
          state_d = ST_DONE;
        end
      end
      ST_INDEX: state_d = ST_DONE;
      ST_CLEAR: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer, merge walks the lanes one per cycle
  always_comb begin
    in_ready_o = 1'b0;
    st_ctl     = '0;
    st_addr    = IdxW'(led_idx_q);
    st_add     = rgb_q;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_CALC:  ;
      ST_MERGE: begin
        st_addr   = lane_idx[cnt_q];
        st_add    = lane_part[cnt_q];
        st_ctl.wr = lane_hit[cnt_q];
      end
      ST_INDEX: st_ctl.wr = idx_ok;
      ST_CLEAR: st_ctl.clr = 1'b1;
      ST_DONE:  load_out = !out_valid_q || out_ready_i;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rgb_q <= ((func_q == FUNC_READ) && idx_ok) ? st_rd : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_rgb_q[0*ChanW +: ChanW];
  assign out_green_o = out_rgb_q[1*ChanW +: ChanW];
  assign out_blue_o  = out_rgb_q[2*ChanW +: ChanW];

endmodule
